/* hw/rtl/lrs_pkg.sv */
// ----------------------------------------------------------------------------
// lrs_pkg: shared types, constants and kernel table of the Lanczos3 resampler
// Holds fixed widths, the one-hot controller states, register indexes and the
// Q16 Lanczos3 table built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none
package lrs_pkg;

  // kernel table
  localparam int KERNEL_STEPS = 64;
  localparam int TAB_LEN      = 3 * KERNEL_STEPS;
  localparam int TAB_IW       = $clog2(TAB_LEN);
  localparam int KW           = 18;  // raw weight, signed Q16

  // taps and datapath widths
  localparam int MAX_TAPS = 6;
  localparam int TAP_W    = 3;
  localparam int IDX_W    = 9;   // source pixel index
  localparam int DIV_W    = 36;  // dividend and quotient
  localparam int DVS_W    = 20;  // divisor
  localparam int CQ_W     = DIV_W + 1;
  localparam int W_W      = 24;  // normalized weight, signed Q16
  localparam int SUM_W    = 21;
  localparam int ACC_W    = 64;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned PI_Q20 = 64'd3294199;

  typedef logic signed [KW-1:0] kent_t;
  typedef kent_t ktab_t [TAB_LEN];

  // controller states
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CDIV = 7'b0000010,
    S_WGT  = 7'b0000100,
    S_NDIV = 7'b0001000,
    S_MAC  = 7'b0010000,
    S_DONE = 7'b0100000,
    S_HOLD = 7'b1000000
  } state_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SRC_W  = 3'd0,
    REG_SRC_H  = 3'd1,
    REG_DST_W  = 3'd2,
    REG_DST_H  = 3'd3,
    REG_CHAN   = 3'd4
  } reg_idx_t;

  // tap window and weight of one axis
  typedef struct packed {
    logic [IDX_W-1:0] first;
    logic [TAP_W-1:0] count;
    logic signed [KW-1:0] weight;
  } axis_t;

  // unsigned 64-bit quotient by shift and subtract, elaboration only
  function automatic longint unsigned udiv64(longint unsigned num,
                                             longint unsigned den);
    logic [64:0] r;
    longint unsigned q;
    r = '0;
    q = '0;
    if (den == 0) return 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // sin(pi*m/n) in Q30, elaboration only
  function automatic longint unsigned sin_pi_q30(longint unsigned m_in,
                                                 longint unsigned n);
    longint unsigned m, x, x2, term;
    longint s;
    m = m_in;
    if (n == 0) return 0;
    if (m > n) m = n;
    if (2 * m > n) m = n - m;
    x = udiv64(PI_Q30 * m, n);
    x2 = (x * x) >> 30;
    term = x;
    s = longint'(x);
    for (int t = 1; t <= 6; t++) begin
      term = udiv64((term * x2) >> 30, longint'((2 * t) * (2 * t + 1)));
      if ((t & 1) == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
    return longint'(s);
  endfunction

  // Lanczos3 table in Q16, elaboration only
  function automatic ktab_t build_ktab();
    ktab_t tb;
    longint unsigned a, b, s1, s2, v, ks, sv, kq;
    sv = longint'(KERNEL_STEPS);
    tb[0] = kent_t'(65536);
    for (int k = 1; k < TAB_LEN; k++) begin
      ks = longint'(k);
      kq = udiv64(ks, sv);
      a  = sin_pi_q30(ks - kq * sv, sv);
      b  = sin_pi_q30(ks, 3 * sv);
      s1 = udiv64(a * sv * 64'd1048576, PI_Q20 * ks);
      s2 = udiv64(b * 3 * sv * 64'd1048576, PI_Q20 * ks);
      v  = (((s1 * s2) >> 30) + 64'd8192) >> 14;
      if ((kq & 64'd1) != 0) tb[k] = -kent_t'(v);
      else tb[k] = kent_t'(v);
    end
    return tb;
  endfunction

  localparam ktab_t KTAB = build_ktab();

endpackage
`default_nettype wire

/* hw/rtl/lanczos3_image_resampler.sv */
// ----------------------------------------------------------------------------
// lanczos3_image_resampler: frame store with Lanczos3 resampled pixel fetch
// Load items write source pixels, fetch items return one resized pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set the
//   source and destination sizes and the channel count; cfg_ready is always
//   high. Write them only while no fetch is in progress.
//   Input transfers (in_valid/in_ready): op 0 loads one pixel into the frame
//   store and gives no result. op 1 fetches destination pixel
//   (pos_x, pos_y); its result leaves on out_valid/out_ready.
//   A fetch runs two centre divisions and up to 12 weight normalizations
//   on the shared bit-serial divider, a table weight lookup per tap, up to
//   36 frame store reads through the MAC pipeline, then the output
//   hand-over. An out-of-range fetch skips straight to the output. One item
//   is in progress at a time.
//   The result sits in an output register, so the next item is accepted
//   while it waits; a fetch finishing into a stalled output holds there.
//   Reset (rst, synchronous) restores the register defaults and empties the
//   output; the frame store holds no defined data until loaded.
// ----------------------------------------------------------------------------
`default_nettype none
module lanczos3_image_resampler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  // input items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [7:0]  pos_x,
  input  wire logic [7:0]  pos_y,
  input  wire logic [15:0] in_ch0,
  input  wire logic [15:0] in_ch1,
  input  wire logic [15:0] in_ch2,
  input  wire logic [15:0] in_ch3,
  // results
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_ch0,
  output logic [15:0]      out_ch1,
  output logic [15:0]      out_ch2,
  output logic [15:0]      out_ch3,
  output logic             out_of_range
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = lrs_pkg::IDX_W;
  localparam int TW    = lrs_pkg::TAP_W;
  localparam int WW    = lrs_pkg::W_W;
  localparam int SW    = lrs_pkg::SUM_W;
  localparam int AC    = lrs_pkg::ACC_W;
  localparam int CQW   = lrs_pkg::CQ_W;
  localparam int DVW   = lrs_pkg::DIV_W;
  localparam int VW    = lrs_pkg::DVS_W;
  localparam logic [8:0] SRC_W_MAX = (MAX_WIDTH < 511) ? 9'(MAX_WIDTH) : 9'd511;
  localparam logic [8:0] SRC_H_MAX = (MAX_HEIGHT < 511) ? 9'(MAX_HEIGHT) : 9'd511;
  localparam logic [8:0] SRC_W_RST = (MAX_WIDTH < 256) ? 9'(MAX_WIDTH) : 9'd256;
  localparam logic [8:0] SRC_H_RST = (MAX_HEIGHT < 256) ? 9'(MAX_HEIGHT) : 9'd256;

  lrs_pkg::state_t state;

  // configuration registers
  logic [8:0] src_w, src_h, dst_w, dst_h;
  logic [2:0] chan;

  // fetch context
  logic [7:0]  px, py;
  logic        oor;
  logic        ax;
  logic        div_wait;
  logic [TW-1:0] tap, a_cnt, b_cnt;
  logic [TW-1:0] nx, ny;
  logic [IW-1:0] fx, fy;
  logic signed [CQW-1:0] cq_x, cq_y;
  logic signed [SW-1:0]  sum_x, sum_y;
  logic signed [WW-1:0]  wx [lrs_pkg::MAX_TAPS];
  logic signed [WW-1:0]  wy [lrs_pkg::MAX_TAPS];
  logic issue_done;

  // MAC pipeline
  logic v1, v2;
  logic signed [2*WW-1:0] p0;
  logic signed [AC-1:0]   prod [4];
  logic signed [AC-1:0]   acc  [4];

  // memory
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0]   mem_rdata;

  // divider
  logic           div_start, div_busy, div_done, div_rnz;
  logic [DVW-1:0] div_dividend, div_q;
  logic [VW-1:0]  div_divisor;

  // axis unit
  lrs_pkg::axis_t ax_o;

  logic in_fire;
  assign in_fire   = in_valid && in_ready;
  assign in_ready  = state == lrs_pkg::S_IDLE;
  assign cfg_ready = 1'b1;

  // clamp of a configuration value into [1, hi]
  function automatic logic [8:0] clamp9(input logic [8:0] v, input logic [8:0] hi);
    logic [8:0] r;
    r = v;
    if (v == '0) r = 9'd1;
    else if (v > hi) r = hi;
    return r;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= SRC_W_RST;
      src_h <= SRC_H_RST;
      dst_w <= 9'd256;
      dst_h <= 9'd256;
      chan  <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lrs_pkg::REG_SRC_W: src_w <= clamp9(cfg_data, SRC_W_MAX);
        lrs_pkg::REG_SRC_H: src_h <= clamp9(cfg_data, SRC_H_MAX);
        lrs_pkg::REG_DST_W: dst_w <= clamp9(cfg_data, 9'd256);
        lrs_pkg::REG_DST_H: dst_h <= clamp9(cfg_data, 9'd256);
        lrs_pkg::REG_CHAN:  chan  <= 3'(clamp9({6'd0, cfg_data[2:0]}, 9'd4));
        default: ;
      endcase
    end
  end

  // centre numerator (2i+1)*src - dst of the current axis
  logic [7:0]         c_i;
  logic [8:0]         c_src, c_dst;
  logic [17:0]        c_prod;
  logic signed [19:0] c_num;
  logic [18:0]        c_mag;
  logic signed [CQW-1:0] c_cq;

  always_comb begin
    c_i    = ax ? py : px;
    c_src  = ax ? src_h : src_w;
    c_dst  = ax ? dst_h : dst_w;
    c_prod = {1'b0, c_i, 1'b1} * {9'd0, c_src};
    c_num  = $signed({2'b0, c_prod}) - $signed({11'd0, c_dst});
    c_mag  = (c_num < 0) ? 19'(-c_num) : 19'(c_num);
    c_cq   = (c_num < 0) ? -($signed({1'b0, div_q}) + CQW'(div_rnz))
                         : $signed({1'b0, div_q});
  end

  // weight currently under normalization
  logic [TW-1:0]         wx_idx, wy_idx;
  logic signed [WW-1:0]  n_w;
  logic signed [SW-1:0]  n_sum;
  logic [TW-1:0]         n_cnt;
  logic [WW-1:0]         n_wabs;
  logic [SW-1:0]         n_sabs;
  logic signed [WW-1:0]  n_res;

  always_comb begin
    wx_idx = (state == lrs_pkg::S_MAC) ? a_cnt : tap;
    wy_idx = (state == lrs_pkg::S_MAC) ? b_cnt : tap;
    n_w    = ax ? wy[wy_idx] : wx[wx_idx];
    n_sum  = ax ? sum_y : sum_x;
    n_cnt  = ax ? ny : nx;
    n_wabs = (n_w < 0) ? WW'(-n_w) : WW'(n_w);
    n_sabs = (n_sum < 0) ? SW'(-n_sum) : SW'(n_sum);
    n_res  = ((n_w < 0) != (n_sum < 0)) ? -$signed(WW'(div_q)) : $signed(WW'(div_q));
  end

  // divider operands
  always_comb begin
    if (state == lrs_pkg::S_CDIV) begin
      div_dividend = DVW'({c_mag, 16'd0});
      div_divisor  = VW'({c_dst, 1'b0});
    end else begin
      div_dividend = DVW'({n_wabs[16:0], 16'd0});
      div_divisor  = VW'(n_sabs);
    end
    div_start = !div_wait && !div_busy &&
                ((state == lrs_pkg::S_CDIV) ||
                 (state == lrs_pkg::S_NDIV && tap < n_cnt && n_sum != '0));
  end

  // memory ports
  logic [IW:0] m_row, m_col;
  always_comb begin
    mem_we    = in_fire && !op && (32'(pos_x) < MAX_WIDTH) && (32'(pos_y) < MAX_HEIGHT);
    mem_waddr = AW'(AW'(pos_y) * AW'(MAX_WIDTH) + AW'(pos_x));
    mem_re    = (state == lrs_pkg::S_MAC) && !issue_done;
    m_row     = {1'b0, fy} + (IW+1)'(b_cnt);
    m_col     = {1'b0, fx} + (IW+1)'(a_cnt);
    mem_raddr = AW'(AW'(m_row) * AW'(MAX_WIDTH) + AW'(m_col));
  end

  // rounded and saturated output sample of one channel
  function automatic logic [15:0] out_sample(input logic signed [AC-1:0] v);
    logic [AC-1:0] r;
    logic [31:0]   h;
    r = AC'(v) + AC'(64'h8000_0000);
    h = r[63:32];
    if (v <= 0) return 16'd0;
    if (h > 32'h0000_FFFF) return 16'hFFFF;
    return h[15:0];
  endfunction

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lrs_pkg::S_IDLE;
      div_wait   <= 1'b0;
      ax         <= 1'b0;
      tap        <= '0;
      issue_done <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (div_start) div_wait <= 1'b1;
      unique case (state)
        lrs_pkg::S_IDLE: begin
          if (in_fire && op) begin
            px <= pos_x;
            py <= pos_y;
            ax <= 1'b0;
            if ({1'b0, pos_x} >= dst_w || {1'b0, pos_y} >= dst_h) begin
              oor   <= 1'b1;
              state <= lrs_pkg::S_DONE;
            end else begin
              oor   <= 1'b0;
              state <= lrs_pkg::S_CDIV;
            end
          end
        end
        lrs_pkg::S_CDIV: begin
          if (div_done) begin
            div_wait <= 1'b0;
            if (!ax) begin
              cq_x <= c_cq;
              ax   <= 1'b1;
            end else begin
              cq_y  <= c_cq;
              ax    <= 1'b0;
              tap   <= '0;
              sum_x <= '0;
              sum_y <= '0;
              state <= lrs_pkg::S_WGT;
            end
          end
        end
        lrs_pkg::S_WGT: begin
          if (tap < ax_o.count) begin
            if (!ax) begin
              wx[tap] <= WW'(ax_o.weight);
              sum_x   <= sum_x + SW'(ax_o.weight);
            end else begin
              wy[tap] <= WW'(ax_o.weight);
              sum_y   <= sum_y + SW'(ax_o.weight);
            end
            tap <= tap + 1'b1;
          end else begin
            tap <= '0;
            if (!ax) begin
              fx <= ax_o.first;
              nx <= ax_o.count;
              ax <= 1'b1;
            end else begin
              fy    <= ax_o.first;
              ny    <= ax_o.count;
              ax    <= 1'b0;
              state <= lrs_pkg::S_NDIV;
            end
          end
        end
        lrs_pkg::S_NDIV: begin
          if (tap >= n_cnt) begin
            tap <= '0;
            if (!ax) begin
              ax <= 1'b1;
            end else begin
              ax         <= 1'b0;
              a_cnt      <= '0;
              b_cnt      <= '0;
              issue_done <= (nx == '0) || (ny == '0);
              state      <= lrs_pkg::S_MAC;
            end
          end else if (n_sum == '0) begin
            tap <= tap + 1'b1;
          end else if (div_done) begin
            div_wait <= 1'b0;
            if (!ax) wx[tap] <= n_res;
            else wy[tap] <= n_res;
            tap <= tap + 1'b1;
          end
        end
        lrs_pkg::S_MAC: begin
          if (!issue_done) begin
            if (a_cnt == nx - 1'b1) begin
              a_cnt <= '0;
              if (b_cnt == ny - 1'b1) issue_done <= 1'b1;
              else b_cnt <= b_cnt + 1'b1;
            end else begin
              a_cnt <= a_cnt + 1'b1;
            end
          end else if (!v1 && !v2) begin
            state <= lrs_pkg::S_DONE;
          end
        end
        lrs_pkg::S_DONE: begin
          state <= lrs_pkg::S_HOLD;
        end
        lrs_pkg::S_HOLD: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= lrs_pkg::S_IDLE;
          end
        end
        default: state <= lrs_pkg::S_IDLE;
      endcase
    end
  end

  // output register, loaded as the result is handed over
  always_ff @(posedge clk) begin
    if (state == lrs_pkg::S_HOLD && (!out_valid || out_ready)) begin
      out_of_range <= oor;
      out_ch0 <= (oor || chan <= 3'd0) ? 16'd0 : out_sample(acc[0]);
      out_ch1 <= (oor || chan <= 3'd1) ? 16'd0 : out_sample(acc[1]);
      out_ch2 <= (oor || chan <= 3'd2) ? 16'd0 : out_sample(acc[2]);
      out_ch3 <= (oor || chan <= 3'd3) ? 16'd0 : out_sample(acc[3]);
    end
  end

  // MAC pipeline: weight product, then sample products, then accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= mem_re;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) p0 <= wy[wy_idx] * wx[wx_idx];
    for (int c = 0; c < 4; c++) begin
      if (v1) prod[c] <= AC'(p0 * $signed({1'b0, mem_rdata[16*c +: 16]}));
      if (state == lrs_pkg::S_NDIV) acc[c] <= '0;
      else if (v2) acc[c] <= acc[c] + prod[c];
    end
  end

  // units
  lrs_frame_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata({in_ch3, in_ch2, in_ch1, in_ch0}),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  lrs_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_q),
    .rem_nz  (div_rnz)
  );

  lrs_axis u_axis (
    .cq (ax ? cq_y : cq_x),
    .src(ax ? src_h : src_w),
    .tap(tap),
    .res(ax_o)
  );

  // checks
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |->
      out_ch0 == 16'd0 && out_ch1 == 16'd0 && out_ch2 == 16'd0 && out_ch3 == 16'd0)
    else $error("out-of-range result with nonzero channels");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !op && !out_valid |=> !out_valid)
    else $error("load produced a result");

endmodule
`default_nettype wire

/* hw/rtl/lrs_frame_store.sv */
// ----------------------------------------------------------------------------
// lrs_frame_store: source pixel memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module lrs_frame_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [63:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [63:0]   rdata
);

  logic [63:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/lrs_divider.sv */
// ----------------------------------------------------------------------------
// lrs_divider: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
`default_nettype none
module lrs_divider (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [lrs_pkg::DIV_W-1:0] dividend,
  input  wire logic [lrs_pkg::DVS_W-1:0] divisor,
  output logic                         busy,
  output logic                         done,
  output logic [lrs_pkg::DIV_W-1:0]    quotient,
  output logic                         rem_nz
);

  localparam int DW = lrs_pkg::DIV_W;
  localparam int VW = lrs_pkg::DVS_W;
  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem, quotient[DW-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign rem_nz = rem != '0;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem      <= VW'(trial - {1'b0, dvs});
        quotient <= {quotient[DW-2:0], 1'b1};
      end else begin
        rem      <= trial[VW-1:0];
        quotient <= {quotient[DW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/lrs_axis.sv */
// ----------------------------------------------------------------------------
// lrs_axis: tap window and raw kernel weight of one axis
// From the Q16 centre gives the clamped first tap, the tap count and the
// table weight of the selected tap.
// ----------------------------------------------------------------------------
`default_nettype none
module lrs_axis (
  input  wire logic signed [lrs_pkg::CQ_W-1:0]  cq,
  input  wire logic        [lrs_pkg::IDX_W-1:0] src,
  input  wire logic        [lrs_pkg::TAP_W-1:0] tap,
  output lrs_pkg::axis_t                        res
);

  localparam int BW = lrs_pkg::CQ_W - 16 + 1;
  localparam int DW = lrs_pkg::CQ_W + 2;
  localparam int MW = DW + $clog2(lrs_pkg::KERNEL_STEPS) + 1;

  logic signed [BW-1:0] ip, left_s, left, right_s, srcm1, r1, r2, cnt_s, jx;
  logic signed [DW-1:0] d;
  logic        [DW-1:0] ad;
  logic        [MW-1:0] idx;

  always_comb begin
    // window bounds
    ip      = BW'(cq >>> 16);
    left_s  = ip - BW'(2);
    left    = (left_s < 0) ? '0 : left_s;
    right_s = ip + BW'(2) + BW'(cq[15:0] != '0);
    srcm1   = $signed(BW'(src)) - BW'(1);
    r1      = (right_s > srcm1) ? srcm1 : right_s;
    r2      = (r1 > left + BW'(lrs_pkg::MAX_TAPS - 1)) ?
              left + BW'(lrs_pkg::MAX_TAPS - 1) : r1;
    cnt_s   = r2 - left + BW'(1);
    res.first = left[lrs_pkg::IDX_W-1:0];
    res.count = (cnt_s <= 0) ? '0 : cnt_s[lrs_pkg::TAP_W-1:0];
    // distance of the tap to the centre and table index, rounded half up
    jx  = left + BW'(tap);
    d   = DW'(cq) - (DW'(jx) <<< 16);
    ad  = (d < 0) ? DW'(-d) : DW'(d);
    idx = (MW'(ad) * MW'(lrs_pkg::KERNEL_STEPS) + MW'(32768)) >> 16;
    res.weight = (idx < MW'(lrs_pkg::TAB_LEN)) ?
                 lrs_pkg::KTAB[idx[lrs_pkg::TAB_IW-1:0]] : '0;
  end

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for lanczos3_image_resampler
// Loads source pixels and fetches resized pixels over a series of register
// settings. Every fetch result is checked field by field against a local
// fixed-point Lanczos3 resampler, with random gaps on both sides and one long
// output stall.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [2:0] REG_NONE = 3'd7;  // index with no register behind it
  localparam logic       OP_LOAD  = 1'b0;
  localparam logic       OP_FETCH = 1'b1;
  localparam int         KSTEPS   = 64;
  localparam int         KLEN     = 3 * KSTEPS;
  localparam longint     Q16      = 65536;

  typedef struct {
    logic        op;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] ch [4];
  } pix_item_t;

  typedef struct {
    logic [15:0] ch [4];
    logic        oor;
  } pix_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic op = 1'b0;
  logic [7:0] pos_x = '0, pos_y = '0;
  logic [15:0] in_ch0 = '0, in_ch1 = '0, in_ch2 = '0, in_ch3 = '0;
  logic out_ready = 1'b0;
  wire logic cfg_ready, in_ready, out_valid, out_of_range;
  wire logic [15:0] out_ch0, out_ch1, out_ch2, out_ch3;

  lanczos3_image_resampler u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .pos_x(pos_x),
    .pos_y(pos_y), .in_ch0(in_ch0), .in_ch1(in_ch1), .in_ch2(in_ch2),
    .in_ch3(in_ch3),
    .out_valid(out_valid), .out_ready(out_ready), .out_ch0(out_ch0),
    .out_ch1(out_ch1), .out_ch2(out_ch2), .out_ch3(out_ch3),
    .out_of_range(out_of_range)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // resampler state mirrored in the testbench
  int          lz_tab [KLEN];
  logic [63:0] pix_mem [65536];
  bit          pix_written [65536];
  int          src_w = 256, src_h = 256, dst_w = 256, dst_h = 256, chan_cnt = 4;

  pix_item_t   pending_px [$];
  pix_result_t resized_q [$];
  pix_item_t   cur_px;
  int          errors = 0;
  int          results_seen = 0;
  int          items_queued = 0;
  bit          quiet = 1'b0;

  // sin(pi*m/n) in Q30 by Taylor series
  function automatic longint unsigned sin_q30(longint unsigned m_in, longint unsigned n);
    longint unsigned m, x, x2, term, dv;
    longint s;
    m = m_in;
    if (n == 0) return 0;
    if (m > n) m = n;
    if (2 * m > n) m = n - m;
    x = 64'd3373259426 * m / n;
    x2 = (x * x) >> 30;
    term = x;
    s = longint'(x);
    for (int t = 1; t <= 6; t++) begin
      dv = longint'((2 * t) * (2 * t + 1));
      term = ((term * x2) >> 30) / dv;
      if (t % 2 == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
    return longint'(s);
  endfunction

  function automatic void fill_lz_tab();
    longint unsigned a, b, s1, s2, v, kk, sv;
    sv = KSTEPS;
    lz_tab[0] = 65536;
    for (int k = 1; k < KLEN; k++) begin
      kk = k;
      a  = sin_q30(kk % sv, sv);
      b  = sin_q30(kk, 3 * sv);
      s1 = (a * sv * 64'd1048576) / (64'd3294199 * kk);
      s2 = (b * 3 * sv * 64'd1048576) / (64'd3294199 * kk);
      v  = (((s1 * s2) >> 30) + 64'd8192) >> 14;
      lz_tab[k] = ((kk / sv) % 2 == 1) ? -int'(v) : int'(v);
    end
  endfunction

  function automatic int sat_reg(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // tap window and normalized Q16 weights of one axis
  function automatic int axis_weights(int i, int src, int dst, output int first,
                                      output longint w [6]);
    longint num, den, cq, ip, frac, lft, rgt, sum, d, idx;
    int n;
    n = 0;
    sum = 0;
    for (int t = 0; t < 6; t++) w[t] = 0;
    num = longint'(2 * i + 1) * src - dst;
    den = 2 * longint'(dst);
    cq = (num >= 0) ? (num * Q16) / den : -(((-num) * Q16 + den - 1) / den);
    ip = (cq >= 0) ? cq / Q16 : -((-cq + Q16 - 1) / Q16);
    frac = cq - ip * Q16;
    lft = ip - 2;
    rgt = ip + 2 + ((frac != 0) ? 1 : 0);
    if (lft < 0) lft = 0;
    if (rgt > src - 1) rgt = src - 1;
    if (rgt > lft + 5) rgt = lft + 5;
    for (longint j = lft; j <= rgt; j++) begin
      d = cq - j * Q16;
      if (d < 0) d = -d;
      idx = (d * KSTEPS + 32768) >>> 16;
      w[n] = (idx < KLEN) ? longint'(lz_tab[idx]) : 0;
      sum += w[n];
      n++;
    end
    if (sum != 0)
      for (int t = 0; t < n; t++) w[t] = (w[t] * Q16) / sum;
    first = int'(lft);
    return n;
  endfunction

  // apply one accepted item: loads update the store, fetches queue a result
  function automatic void resample_accept(pix_item_t it);
    pix_result_t r;
    longint wx [6], wy [6], acc [4], row [4], v;
    int fx, fy, nx, ny;
    logic [63:0] word;
    if (it.op == OP_LOAD) begin
      pix_mem[{it.y, it.x}] = {it.ch[3], it.ch[2], it.ch[1], it.ch[0]};
      return;
    end
    for (int c = 0; c < 4; c++) r.ch[c] = '0;
    if (it.x >= dst_w || it.y >= dst_h) begin
      r.oor = 1'b1;
      resized_q.push_back(r);
      return;
    end
    nx = axis_weights(it.x, src_w, dst_w, fx, wx);
    ny = axis_weights(it.y, src_h, dst_h, fy, wy);
    for (int c = 0; c < 4; c++) acc[c] = 0;
    for (int b = 0; b < ny; b++) begin
      for (int c = 0; c < 4; c++) row[c] = 0;
      for (int a = 0; a < nx; a++) begin
        word = pix_mem[(fy + b) * 256 + fx + a];
        for (int c = 0; c < 4; c++) row[c] += wx[a] * longint'(word[16*c +: 16]);
      end
      for (int c = 0; c < 4; c++) acc[c] += wy[b] * row[c];
    end
    for (int c = 0; c < 4; c++) begin
      v = 0;
      if (c < chan_cnt && acc[c] > 0) begin
        v = (acc[c] + 64'sh80000000) >>> 32;
        if (v > 65535) v = 65535;
      end
      r.ch[c] = v[15:0];
    end
    r.oor = 1'b0;
    resized_q.push_back(r);
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: input transfers
  int gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap <= 0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) resample_accept(cur_px);
      if (gap > 0) begin
        gap <= gap - 1;
        in_valid <= 1'b0;
      end else if (pending_px.size() > 0) begin
        cur_px = pending_px.pop_front();
        op <= cur_px.op;
        pos_x <= cur_px.x;
        pos_y <= cur_px.y;
        in_ch0 <= cur_px.ch[0];
        in_ch1 <= cur_px.ch[1];
        in_ch2 <= cur_px.ch[2];
        in_ch3 <= cur_px.ch[3];
        in_valid <= 1'b1;
        gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // monitor: result transfers, random stalls and one long hold-off
  int  stall = 0;
  bit  held = 1'b0;
  always @(posedge clk) begin
    pix_result_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (resized_q.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, actual ch0 %0d oor %0d",
                   $time, out_ch0, out_of_range);
        end else begin
          e = resized_q.pop_front();
          check_field("out_ch0", e.ch[0], out_ch0);
          check_field("out_ch1", e.ch[1], out_ch1);
          check_field("out_ch2", e.ch[2], out_ch2);
          check_field("out_ch3", e.ch[3], out_ch3);
          check_field("out_of_range", e.oor, out_of_range);
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        out_ready <= 1'b0;
      end else if (!held && results_seen == 30) begin
        held <= 1'b1;
        stall <= 3000;
        out_ready <= 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 199) == 0) begin
        stall <= $urandom_range(10, 60);
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [8:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lrs_pkg::REG_SRC_W: src_w = sat_reg(val, 256);
      lrs_pkg::REG_SRC_H: src_h = sat_reg(val, 256);
      lrs_pkg::REG_DST_W: dst_w = sat_reg(val, 256);
      lrs_pkg::REG_DST_H: dst_h = sat_reg(val, 256);
      lrs_pkg::REG_CHAN:  chan_cnt = sat_reg(val[2:0], 4);
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'hFFFF;
    if (r < 20) return 16'h0000;
    return $urandom_range(0, 65535);
  endfunction

  function automatic void queue_px(logic o, int x, int y);
    pix_item_t it;
    it.op = o;
    it.x = x;
    it.y = y;
    for (int c = 0; c < 4; c++) it.ch[c] = pick_sample();
    if (o == OP_LOAD) pix_written[{it.y, it.x}] = 1'b1;
    pending_px.push_back(it);
    items_queued++;
  endfunction

  // wait until the block is idle with nothing outstanding
  task automatic drain();
    do @(posedge clk);
    while (pending_px.size() != 0 || in_valid || resized_q.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  // one register setting: program, load the source area, then fetch and load at random
  task automatic run_phase(int sw, int sh, int dw, int dh, int ch, int nfetch);
    int r;
    drain();
    cfg_write(lrs_pkg::REG_SRC_W, sw);
    cfg_write(lrs_pkg::REG_SRC_H, sh);
    cfg_write(lrs_pkg::REG_DST_W, dw);
    cfg_write(lrs_pkg::REG_DST_H, dh);
    cfg_write(lrs_pkg::REG_CHAN, ch);
    for (int y = 0; y < src_h; y++)
      for (int x = 0; x < src_w; x++)
        if (!pix_written[y * 256 + x]) queue_px(OP_LOAD, x, y);
    // corners of the destination and the first pixel past each edge
    queue_px(OP_FETCH, 0, 0);
    queue_px(OP_FETCH, dst_w - 1, dst_h - 1);
    queue_px(OP_FETCH, dst_w - 1, 0);
    queue_px(OP_FETCH, 0, dst_h - 1);
    if (dst_w < 256) queue_px(OP_FETCH, dst_w, 0);
    if (dst_h < 256) queue_px(OP_FETCH, 0, dst_h);
    for (int n = 0; n < nfetch; n++) begin
      r = $urandom_range(0, 99);
      if (r < 8) queue_px(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 255));
      else if (r < 16) queue_px(OP_LOAD, $urandom_range(0, src_w - 1),
                                $urandom_range(0, src_h - 1));
      else if (r < 24) queue_px(OP_FETCH, $urandom_range(0, 255), $urandom_range(0, 255));
      else queue_px(OP_FETCH, $urandom_range(0, dst_w - 1), $urandom_range(0, dst_h - 1));
    end
  endtask

  // main sequence
  initial begin
    fill_lz_tab();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // zero values clamp to one: single pixel, single channel
    run_phase(0, 0, 0, 0, 0, 6);
    // over-range values saturate; widest source row
    run_phase(511, 1, 3, 9, 7, 10);
    cfg_write(REG_NONE, 9'h1FF);
    // tallest source column, widest destination
    run_phase(1, 256, 256, 2, 4, 10);
    run_phase(8, 8, 16, 16, 2, 30);
    run_phase(16, 12, 5, 7, 3, 30);
    quiet = 1'b1;
    run_phase(6, 6, 12, 3, 4, 20);
    quiet = 1'b0;
    while (items_queued < 1900) begin
      quiet = ($urandom_range(0, 5) == 0);
      run_phase($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 40),
                $urandom_range(0, 40), $urandom_range(0, 7), 80);
    end
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // run limit
  initial begin
    #(64'd60000000);
    $display("FAILURE");
    $finish;
  end

endmodule
